### rtl/ved_pkg.sv
package ved_pkg;

   // configuration port geometry
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_LEN_W  = 13;
   localparam int CSR_DATA_W = 13;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_COMPLEX_MODE  = 1'b1;

   // result width
   localparam int DIST_W = 23;

   // configuration handed to the accumulator
   typedef struct packed {
      logic [CSR_LEN_W-1:0] vector_length;
      logic                 complex_mode;
   } cfg_type;

endpackage

### rtl/ved_accum.sv
module ved_accum #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int MAX_LENGTH   = 4096,
   parameter int SUM_W        = 47
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           req_accept,
   input  logic signed [SAMPLE_WIDTH-1:0] a_real,
   input  logic signed [SAMPLE_WIDTH-1:0] a_imag,
   input  logic signed [SAMPLE_WIDTH-1:0] b_real,
   input  logic signed [SAMPLE_WIDTH-1:0] b_imag,
   input  ved_pkg::cfg_type               cfg,
   output logic                           total_valid,
   output logic [SUM_W-1:0]               total
);
   import ved_pkg::*;

   localparam int DIFF_W = SAMPLE_WIDTH + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int SQ_W   = 2 * SAMPLE_WIDTH + 1;
   localparam int ADD_W  = SQ_W + 1;
   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int CMP_W  = ((LEN_W > CSR_LEN_W) ? LEN_W : CSR_LEN_W) + 1;

   // element counter and end-of-vector detect
   logic [LEN_W-1:0] count_ff, count_in;
   logic [CMP_W-1:0] len_raw, len_max, len_eff, count_next;
   logic             last;

   // stage a: differences
   logic signed [DIFF_W-1:0] diff_r_ff, diff_r_in, diff_i_ff, diff_i_in;
   logic                     a_vld_ff, a_last_ff;

   // stage b: squares summed
   logic signed [PROD_W-1:0] prod_r, prod_i;
   logic [ADD_W-1:0]         add_ff, add_in;
   logic                     b_vld_ff, b_last_ff;

   // stage c: running sum
   logic [SUM_W-1:0] sum_ff, sum_in, tot_ff, tot_in, tot_next;
   logic             tv_ff, tv_in;

   // effective length, clamped to 1..MAX_LENGTH
   always_comb begin
      len_raw    = CMP_W'(cfg.vector_length);
      len_max    = CMP_W'(MAX_LENGTH);
      if (len_raw == '0) begin
         len_eff = CMP_W'(1);
      end else if (len_raw > len_max) begin
         len_eff = len_max;
      end else begin
         len_eff = len_raw;
      end
      count_next = CMP_W'(count_ff) + CMP_W'(1);
      last       = (count_next >= len_eff);
      count_in   = last ? '0 : LEN_W'(count_next);
   end

   // differences, imaginary part only in complex mode
   always_comb begin
      diff_r_in = DIFF_W'(a_real) - DIFF_W'(b_real);
      diff_i_in = cfg.complex_mode ? (DIFF_W'(a_imag) - DIFF_W'(b_imag)) : '0;
   end

   // squares and their sum
   always_comb begin
      prod_r = PROD_W'(diff_r_ff) * PROD_W'(diff_r_ff);
      prod_i = PROD_W'(diff_i_ff) * PROD_W'(diff_i_ff);
      add_in = ADD_W'(prod_r[SQ_W-1:0]) + ADD_W'(prod_i[SQ_W-1:0]);
   end

   // accumulate, hand the total on at the end of a vector
   always_comb begin
      tot_next = sum_ff + SUM_W'(add_ff);
      sum_in   = sum_ff;
      tot_in   = tot_ff;
      tv_in    = 1'b0;
      if (b_vld_ff) begin
         if (b_last_ff) begin
            sum_in = '0;
            tot_in = tot_next;
            tv_in  = 1'b1;
         end else begin
            sum_in = tot_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         a_vld_ff  <= 1'b0;
         a_last_ff <= 1'b0;
         b_vld_ff  <= 1'b0;
         b_last_ff <= 1'b0;
         sum_ff    <= '0;
         tv_ff     <= 1'b0;
      end else if (advance) begin
         if (req_accept) begin
            count_ff <= count_in;
         end
         a_vld_ff  <= req_accept;
         a_last_ff <= last;
         b_vld_ff  <= a_vld_ff;
         b_last_ff <= a_last_ff;
         sum_ff    <= sum_in;
         tv_ff     <= tv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         diff_r_ff <= diff_r_in;
         diff_i_ff <= diff_i_in;
         add_ff    <= add_in;
         tot_ff    <= tot_in;
      end
   end

   assign total_valid = tv_ff;
   assign total       = tot_ff;

endmodule

### rtl/ved_sqrt_cell.sv
module ved_sqrt_cell #(
   parameter int REM_W  = 47,
   parameter int ROOT_W = 48,
   parameter int SHIFT  = 46
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              vld_i,
   input  logic [REM_W-1:0]  rem_i,
   input  logic [ROOT_W-1:0] root_i,
   output logic              vld_o,
   output logic [REM_W-1:0]  rem_o,
   output logic [ROOT_W-1:0] root_o
);
   localparam int CW = (REM_W > ROOT_W + 1) ? REM_W : ROOT_W + 1;
   localparam logic [ROOT_W:0] BIT = {{ROOT_W{1'b0}}, 1'b1} << SHIFT;

   logic              vld_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CW-1:0]     trial;
   logic              ge;

   // one restoring square-root step for this bit pair
   always_comb begin
      trial = CW'({1'b0, root_i} + BIT);
      ge    = (CW'(rem_i) >= trial);
      if (ge) begin
         rem_in  = REM_W'(CW'(rem_i) - trial);
         root_in = ROOT_W'(({1'b0, root_i} >> 1) + BIT);
      end else begin
         rem_in  = rem_i;
         root_in = root_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign vld_o  = vld_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

### rtl/vector_euclidean_distance_top.sv
// channel  | handshake               | payload
// req      | req_valid / req_ready   | req_a_real, req_a_imag, req_b_real, req_b_imag
// rsp      | rsp_valid / rsp_ready   | rsp_distance
// csr      | csr_write_enable        | csr_index, csr_write_data
//
// one element pair per cycle is taken while the result side keeps up
// the last pair of a vector passes 3 + (SUM_W+1)/2 + 1 registers (28 at defaults):
// stages a, b, c, the square-root cells, the output register; one root bit per cell
// a held result (rsp_valid high, rsp_ready low) freezes the whole pipeline and
// drops req_ready; synchronous reset empties it and restores length 1, real mode
module vector_euclidean_distance_top #(
   parameter int MAX_LENGTH   = 4096,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_a_real,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_a_imag,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_b_real,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_b_imag,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ved_pkg::DIST_W-1:0]         rsp_distance,
   input  logic                               csr_write_enable,
   input  logic [ved_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ved_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import ved_pkg::*;

   localparam int SUM_W  = 2 * SAMPLE_WIDTH + 2 + $clog2(MAX_LENGTH) + 1;
   localparam int STEPS  = (SUM_W + 1) / 2;
   localparam int ROOT_W = (2 * STEPS > DIST_W) ? 2 * STEPS : DIST_W;

   cfg_type          cfg_ff;
   logic             advance, req_accept;
   logic             total_valid;
   logic [SUM_W-1:0] total;

   logic              vld_s  [0:STEPS];
   logic [SUM_W-1:0]  rem_s  [0:STEPS];
   logic [ROOT_W-1:0] root_s [0:STEPS];

   logic              rsp_valid_ff;
   logic [DIST_W-1:0] dist_ff;

   // whole pipeline moves unless a result is held
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = advance;
   assign req_accept = req_valid && advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vector_length <= CSR_LEN_W'(1);
         cfg_ff.complex_mode  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_VECTOR_LENGTH: cfg_ff.vector_length <= csr_write_data[CSR_LEN_W-1:0];
            REG_COMPLEX_MODE:  cfg_ff.complex_mode  <= csr_write_data[0];
         endcase
      end
   end

   // differences, squares and running sum
   ved_accum #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_LENGTH   (MAX_LENGTH),
      .SUM_W        (SUM_W)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_accept  (req_accept),
      .a_real      (req_a_real),
      .a_imag      (req_a_imag),
      .b_real      (req_b_real),
      .b_imag      (req_b_imag),
      .cfg         (cfg_ff),
      .total_valid (total_valid),
      .total       (total)
   );

   // square-root cell row
   assign vld_s[0]  = total_valid;
   assign rem_s[0]  = total;
   assign root_s[0] = '0;

   for (genvar k = 0; k < STEPS; k++) begin : g_cell
      ved_sqrt_cell #(
         .REM_W  (SUM_W),
         .ROOT_W (ROOT_W),
         .SHIFT  (2 * (STEPS - 1 - k))
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .vld_i   (vld_s[k]),
         .rem_i   (rem_s[k]),
         .root_i  (root_s[k]),
         .vld_o   (vld_s[k+1]),
         .rem_o   (rem_s[k+1]),
         .root_o  (root_s[k+1])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_s[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff <= root_s[STEPS][DIST_W-1:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = dist_ff;

endmodule
